### rtl/core/pfcc_pkg.sv
// Shared types, constants and CRC step for the frame checker.
package pfcc_pkg;

  localparam int unsigned POS_W = 17;

  localparam logic [15:0]      CRC_INIT  = 16'hFFFF;
  localparam logic [15:0]      CRC_POLY  = 16'h1021;
  localparam logic [7:0]       TYPE_MASK = 8'h0F;
  localparam logic [POS_W-1:0] POS_MAX   = 17'h1FFFF;
  localparam logic [POS_W-1:0] POS_TYPE  = 17'd0;
  localparam logic [POS_W-1:0] POS_LEN_H = 17'd1;
  localparam logic [POS_W-1:0] POS_LEN_L = 17'd2;
  localparam logic [POS_W-1:0] HDR_BYTES = 17'd3;
  localparam logic [POS_W-1:0] OVERHEAD  = 17'd4;

  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data_byte;
    logic [3:0]  frame_type;
    logic [15:0] payload_length;
    logic        frame_ok;
  } result_t;

  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

### rtl/core/pfcc_if.sv
// Valid/ready channel interfaces for frame bytes and check results.
interface pfcc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       end_of_frame;

  modport source (output valid, output frame_byte, output end_of_frame, input ready);
  modport sink (input valid, input frame_byte, input end_of_frame, output ready);
endinterface

interface pfcc_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  data_byte;
  logic [3:0]  frame_type;
  logic [15:0] payload_length;
  logic        frame_ok;

  modport source (output valid, output kind, output data_byte, output frame_type,
                  output payload_length, output frame_ok, input ready);
  modport sink (input valid, input kind, input data_byte, input frame_type,
                input payload_length, input frame_ok, output ready);
endinterface

### rtl/core/pfcc_out_buf.sv
// Two-entry skid buffer that holds result items for the output channel.
module pfcc_out_buf (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  pfcc_pkg::result_t push_item,
  output logic              space,
  pfcc_out_if.source        results
);
  import pfcc_pkg::*;

  logic    main_valid;
  logic    skid_valid;
  result_t main_item;
  result_t skid_item;
  logic    pop;

  assign space = !skid_valid;
  assign pop   = main_valid && results.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        main_item  <= skid_item;
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!main_valid || pop) begin
        main_item  <= push_item;
        main_valid <= 1'b1;
      end else begin
        skid_item  <= push_item;
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      main_valid <= 1'b0;
    end
  end

  assign results.valid          = main_valid;
  assign results.kind           = main_item.kind;
  assign results.data_byte      = main_item.data_byte;
  assign results.frame_type     = main_item.frame_type;
  assign results.payload_length = main_item.payload_length;
  assign results.frame_ok       = main_item.frame_ok;

endmodule

### rtl/core/pdu_frame_crc16_checker.sv
// Top level of the length-prefixed frame checker with CRC-16 CCITT-FALSE.
//
// Usage:
//   frames  : one frame byte per item, end_of_frame set on the last byte.
//             Byte 0 carries the type nibble, bytes 1-2 the payload length
//             (big-endian), then the payload, then the CRC (big-endian).
//   results : kind 0 forwards a payload byte as it arrives, before the CRC
//             is known; kind 1 is the status item for a finished frame with
//             type, declared length and frame_ok. Discard payload on a bad status.
//   Path: an accepted byte is held in an input register, checked there against
//   the frame state, and its result is registered in the output buffer.
//   Throughput: one byte per cycle while the output buffer has space or the
//   byte produces no result; the CRC of one byte is an eight-step XOR network
//   between the input register and the CRC register.
//   Reset: the frame state returns to position zero with CRC FFFF, and both
//   the input register and the two-entry output buffer are emptied.
//   Stall: while results.ready is low the output buffer holds up to two items;
//   once full, frames.ready drops for bytes that produce a result.
module pdu_frame_crc16_checker (
  input  logic       clk,
  input  logic       rst,
  pfcc_in_if.sink    frames,
  pfcc_out_if.source results
);
  import pfcc_pkg::*;

  logic             s1_valid;
  logic [7:0]       s1_byte;
  logic             s1_eof;

  logic [POS_W-1:0] pos;
  logic [15:0]      crc;
  logic [3:0]       held_type;
  logic [15:0]      held_length;
  logic [15:0]      received_crc;

  logic [POS_W-1:0] pos_next;
  logic [15:0]      crc_next;
  logic [3:0]       held_type_next;
  logic [15:0]      held_length_next;
  logic [15:0]      received_crc_next;

  logic             in_payload;
  logic             emits;
  logic             go;
  logic             buf_space;
  result_t          item;
  logic [15:0]      crc_step;
  logic             len_match;

  assign crc_step   = crc_feed(crc, s1_byte);
  assign in_payload = (pos >= HDR_BYTES) && ((pos - HDR_BYTES) < {1'b0, held_length});
  assign emits      = s1_eof || in_payload;
  assign go         = s1_valid && (!emits || buf_space);

  assign frames.ready = !s1_valid || go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (frames.ready) begin
      s1_valid <= frames.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (frames.ready && frames.valid) begin
      s1_byte <= frames.frame_byte;
      s1_eof  <= frames.end_of_frame;
    end
  end

  always_comb begin
    held_type_next    = held_type;
    held_length_next  = held_length;
    received_crc_next = received_crc;
    crc_next          = crc;
    if (pos == POS_TYPE) begin
      held_type_next = s1_byte[3:0] & TYPE_MASK[3:0];
    end else if (pos == POS_LEN_H) begin
      held_length_next = {s1_byte, held_length[7:0]};
    end else if (pos == POS_LEN_L) begin
      held_length_next = {held_length[15:8], s1_byte};
    end
    if (pos < HDR_BYTES || in_payload) begin
      crc_next = crc_step;
    end else begin
      received_crc_next = {received_crc[7:0], s1_byte};
    end
    pos_next = (pos == POS_MAX) ? pos : pos + 1'b1;
  end

  assign len_match = (pos == ({1'b0, held_length_next} + OVERHEAD));

  always_comb begin
    item = '0;
    if (s1_eof) begin
      item.kind           = KIND_STATUS;
      item.frame_type     = held_type_next;
      item.payload_length = held_length_next;
      item.frame_ok       = len_match && (received_crc_next == crc_next);
    end else begin
      item.kind      = KIND_DATA;
      item.data_byte = s1_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (go && s1_eof)) begin
      pos          <= '0;
      crc          <= CRC_INIT;
      held_type    <= '0;
      held_length  <= '0;
      received_crc <= '0;
    end else if (go) begin
      pos          <= pos_next;
      crc          <= crc_next;
      held_type    <= held_type_next;
      held_length  <= held_length_next;
      received_crc <= received_crc_next;
    end
  end

  pfcc_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (go && emits),
    .push_item (item),
    .space     (buf_space),
    .results   (results)
  );

  a_eof_clears: assert property (@(posedge clk) disable iff (rst)
    go && s1_eof |=> pos == '0 && crc == CRC_INIT)
    else $error("frame state not cleared after final byte");

  a_pos_grows: assert property (@(posedge clk) disable iff (rst)
    go && !s1_eof |=> pos >= $past(pos) && pos != '0)
    else $error("byte position went back inside a frame");

  a_status_clean: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.kind == KIND_STATUS |-> results.data_byte == 8'h00)
    else $error("status item carries a data byte");

  a_data_clean: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.kind == KIND_DATA |->
      results.frame_type == 4'h0 && results.payload_length == 16'h0000 && !results.frame_ok)
    else $error("payload item carries status fields");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    s1_valid && emits && !buf_space |-> !frames.ready)
    else $error("byte taken while output buffer is full");

endmodule

### dv/frame_check_tb_pkg.sv
// Frame tracker for the CRC-16 frame checker bench: predicts results and checks them.
package frame_check_tb_pkg;
  import pfcc_pkg::*;

  class crc_frame_tracker;
    localparam int unsigned MIN_FRAME = 5;

    bit [POS_W-1:0] pos;
    bit [15:0]      crc;
    bit [3:0]       ftype;
    bit [15:0]      flen;
    bit [15:0]      rx_crc;
    result_t        awaited[$];
    int unsigned    errors;
    int unsigned    data_seen;
    int unsigned    good_seen;
    int unsigned    bad_seen;

    function new();
      clear_frame();
    endfunction

    function void clear_frame();
      pos    = '0;
      crc    = CRC_INIT;
      ftype  = '0;
      flen   = '0;
      rx_crc = '0;
    endfunction

    static function bit [15:0] ccitt_step(bit [15:0] c, bit [7:0] b);
      bit fb;
      for (int i = 7; i >= 0; i--) begin
        fb = c[15] ^ b[i];
        c  = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
      end
      return c;
    endfunction

    function void note_byte(bit [7:0] b, bit eof);
      result_t     r;
      int unsigned p;
      int unsigned total;
      bit          fwd;
      p   = pos;
      fwd = 1'b0;
      r   = '0;
      case (pos)
        POS_TYPE:  ftype = 4'(b & TYPE_MASK);
        POS_LEN_H: flen[15:8] = b;
        POS_LEN_L: flen[7:0] = b;
        default: ;
      endcase
      if (p < HDR_BYTES) begin
        crc = ccitt_step(crc, b);
      end else if (p - HDR_BYTES < flen) begin
        crc = ccitt_step(crc, b);
        fwd = 1'b1;
      end else begin
        rx_crc = {rx_crc[7:0], b};
      end
      if (eof) begin
        total            = p + 1;
        r.kind           = KIND_STATUS;
        r.frame_type     = ftype;
        r.payload_length = flen;
        r.frame_ok       = (total >= MIN_FRAME) && (total == MIN_FRAME + flen) &&
                           (rx_crc == crc);
        awaited.push_back(r);
        clear_frame();
        return;
      end
      if (pos != POS_MAX) pos++;
      if (fwd) begin
        r.kind      = KIND_DATA;
        r.data_byte = b;
        awaited.push_back(r);
      end
    endfunction

    task report(string what);
      errors++;
      if (errors <= 40) $display("MISMATCH @%0t: %s", $time, what);
    endtask

    task check_result(result_t got);
      result_t want;
      if (awaited.size() == 0) begin
        report($sformatf("unexpected item kind=%0b data=%02h", got.kind, got.data_byte));
        return;
      end
      want = awaited.pop_front();
      if (got.kind !== want.kind)
        report($sformatf("kind %0b, want %0b", got.kind, want.kind));
      if (got.data_byte !== want.data_byte)
        report($sformatf("data_byte %02h, want %02h", got.data_byte, want.data_byte));
      if (got.frame_type !== want.frame_type)
        report($sformatf("frame_type %0h, want %0h", got.frame_type, want.frame_type));
      if (got.payload_length !== want.payload_length)
        report($sformatf("payload_length %04h, want %04h",
                         got.payload_length, want.payload_length));
      if (got.frame_ok !== want.frame_ok)
        report($sformatf("frame_ok %0b, want %0b", got.frame_ok, want.frame_ok));
      if (want.kind == KIND_STATUS) begin
        if (want.frame_ok) good_seen++;
        else bad_seen++;
      end else begin
        data_seen++;
      end
    endtask
  endclass

endpackage

### dv/tb_top.sv
// Top-level bench for the frame checker: drives frames, checks payload and status items.
module tb_top;
  import pfcc_pkg::*;
  import frame_check_tb_pkg::*;

  typedef bit [7:0] octets_t[$];

  localparam int unsigned RANDOM_ITEMS = 1050;
  localparam int unsigned QUIET_AFTER  = 900;
  localparam int unsigned STALL_LIMIT  = 1000;

  logic clk;
  logic rst;
  bit   quiet;
  int unsigned bytes_in;
  int unsigned frames_sent;
  int unsigned stall_cycles;
  crc_frame_tracker tracker;

  pfcc_in_if  frames_ch ();
  pfcc_out_if results_ch ();

  pdu_frame_crc16_checker DUT (
    .clk     (clk),
    .rst     (rst),
    .frames  (frames_ch),
    .results (results_ch)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic octets_t with_crc(octets_t q);
    bit [15:0] c = CRC_INIT;
    foreach (q[i]) c = crc_frame_tracker::ccitt_step(c, q[i]);
    q.push_back(c[15:8]);
    q.push_back(c[7:0]);
    return q;
  endfunction

  function automatic octets_t good_frame(bit [7:0] hdr, int unsigned len);
    octets_t q;
    q.push_back(hdr);
    q.push_back(8'(len >> 8));
    q.push_back(8'(len));
    repeat (len) q.push_back(8'($urandom));
    return with_crc(q);
  endfunction

  task send_byte(bit [7:0] b, bit eof, bit calm);
    if (!quiet && !calm && $urandom_range(0, 9) == 0) begin
      frames_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    frames_ch.valid        <= 1'b1;
    frames_ch.frame_byte   <= b;
    frames_ch.end_of_frame <= eof;
    do @(posedge clk); while (!frames_ch.ready);
    tracker.note_byte(b, eof);
    bytes_in++;
    @(negedge clk);
  endtask

  task send_frame(octets_t q);
    bit calm;
    calm = ($urandom_range(0, 3) == 0);
    foreach (q[i]) send_byte(q[i], i == q.size() - 1, calm);
    frames_sent++;
  endtask

  initial begin
    results_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (!quiet && $urandom_range(0, 5) == 0) begin
        results_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(negedge clk);
      end
      results_ch.ready <= 1'b1;
      repeat ($urandom_range(1, ($urandom_range(0, 9) == 0) ? 200 : 20)) @(negedge clk);
    end
  end

  always @(posedge clk) begin : result_monitor
    result_t got;
    if (!rst && results_ch.valid && results_ch.ready) begin
      got.kind           = results_ch.kind;
      got.data_byte      = results_ch.data_byte;
      got.frame_type     = results_ch.frame_type;
      got.payload_length = results_ch.payload_length;
      got.frame_ok       = results_ch.frame_ok;
      tracker.check_result(got);
    end
  end

  always @(posedge clk) begin
    if (rst || (frames_ch.valid && frames_ch.ready) ||
        (results_ch.valid && results_ch.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("tb_top failed");
        $finish;
      end
    end
  end

  initial begin
    octets_t     f;
    int unsigned pick;
    int unsigned len;
    int unsigned cut;
    int unsigned idx;
    tracker                = new();
    quiet                  = 1'b0;
    bytes_in               = 0;
    frames_sent            = 0;
    stall_cycles           = 0;
    rst                    = 1'b1;
    frames_ch.valid        = 1'b0;
    frames_ch.frame_byte   = 8'h00;
    frames_ch.end_of_frame = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    f = {8'hFF, 8'h00, 8'h00};
    send_frame(with_crc(f));
    f = {8'h00, 8'h00, 8'h01, 8'h80};
    send_frame(with_crc(f));
    f = {8'h37};
    send_frame(f);
    f = {8'h12, 8'hAB};
    send_frame(f);
    f = {8'h04, 8'hFF, 8'hFF, 8'h11, 8'h22};
    send_frame(f);
    f = {8'hF0, 8'h00, 8'h00};
    f = with_crc(f);
    f[4] ^= 8'h01;
    send_frame(f);
    f = {8'h09, 8'h00, 8'h00};
    f = with_crc(f);
    f.push_back(8'h5C);
    send_frame(f);

    while (bytes_in < RANDOM_ITEMS) begin
      if (bytes_in > QUIET_AFTER) quiet = 1'b1;
      pick = $urandom_range(0, 9);
      len  = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 48) : $urandom_range(0, 12);
      f    = good_frame(8'($urandom), len);
      case (pick)
        7: begin
          idx = $urandom_range(0, f.size() - 1);
          f[idx] ^= 8'(1 << $urandom_range(0, 7));
        end
        8: begin
          cut = $urandom_range(1, f.size() - 1);
          f   = f[0:cut-1];
        end
        9: begin
          if ($urandom_range(0, 1) == 0) begin
            repeat ($urandom_range(1, 3)) f.push_back(8'($urandom));
          end else begin
            f.delete();
            repeat ($urandom_range(1, 8)) f.push_back(8'($urandom));
          end
        end
        default: ;
      endcase
      send_frame(f);
    end

    quiet = 1'b1;
    frames_ch.valid <= 1'b0;
    while (tracker.awaited.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("Run covered %0d frames (%0d bytes): good, short, truncated, corrupt, padded;",
             frames_sent, bytes_in);
    $display("%0d payload bytes, %0d good / %0d bad statuses.",
             tracker.data_seen, tracker.good_seen, tracker.bad_seen);
    if (tracker.errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
